// ----- rtl/core/rrp_pkg.sv -----
// Shared types and constants for the reservoir random pick block.
`default_nettype none
package rrp_pkg;

   localparam int ACTION_W = 2;
   localparam int TIMER_W  = 32;
   localparam int ID_W     = 16;
   localparam int SIZE_W   = 32;
   localparam int COUNT_W  = 16;
   localparam int MAXSZ_W  = 21;
   localparam int SEED_W   = 32;
   localparam int STEP_W   = 4;

   localparam logic [ACTION_W-1:0] ACT_SEED  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_OFFER = 2'd2;

   localparam logic [SEED_W-1:0]  LCG_MUL        = 32'd1664525;
   localparam logic [SEED_W-1:0]  LCG_ADD        = 32'd1013904223;
   localparam logic [SEED_W-1:0]  SEED_OFFSET    = 32'd42;
   localparam logic [SEED_W-1:0]  SEED_RESET     = 32'd1;
   localparam logic [MAXSZ_W-1:0] MAX_SIZE_RESET = 21'd32768;

   typedef struct packed {
      logic capture;
      logic exec;
      logic lcg_step;
      logic div_load;
      logic div_step;
      logic commit;
   } rrp_cmd_type;

   typedef struct packed {
      logic need_lcg;
      logic count_zero;
      logic div_last;
   } rrp_stat_type;

endpackage
`default_nettype wire

// ----- rtl/core/rrp_intf.sv -----
// Request and response channel interfaces of the reservoir random pick block.
`default_nettype none
interface rrp_req_if
   import rrp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TIMER_W-1:0]  timer_value;
   logic [ID_W-1:0]     entry_id;
   logic [SIZE_W-1:0]   entry_size;
   logic                is_hidden;

   modport source (output valid, action, timer_value, entry_id, entry_size, is_hidden,
                   input ready);
   modport sink   (input valid, action, timer_value, entry_id, entry_size, is_hidden,
                   output ready);
endinterface

interface rrp_rsp_if
   import rrp_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] entry_count;
   logic [ID_W-1:0]    chosen_id;
   logic               has_choice;
   logic               taken_now;

   modport source (output valid, entry_count, chosen_id, has_choice, taken_now,
                   input ready);
   modport sink   (input valid, entry_count, chosen_id, has_choice, taken_now,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/reservoir_random_pick_core.sv -----
// Top level of the reservoir random pick block.
// Picks one entry uniformly at random from a stream of offered entries
// (reservoir sampling of size one, 32-bit LCG). Every request word gives one
// response word with the state after the update. Seed, start-scan and ignored
// or ineligible words pass from capture through the execute state to commit; so
// does the first eligible offer of a scan. An offer whose count wrapped to zero
// adds the LCG multiply, and any other eligible offer adds the LCG multiply, the
// modulo load and the restoring modulo of the seed's upper half by the count. One word
// is in work at a time; a finished response waits in its output register while
// the next word is accepted and worked on. The user must write max_size through
// csr_write/csr_wdata while the block is idle; the block does not enforce this.
`default_nettype none
module reservoir_random_pick_core
   import rrp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic [MAXSZ_W-1:0] csr_wdata,
   rrp_req_if.sink                 req_if,
   rrp_rsp_if.source               rsp_if
);

   rrp_cmd_type  cmd;
   rrp_stat_type stat;

   rrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .in_action (req_if.action),
      .in_timer  (req_if.timer_value),
      .in_id     (req_if.entry_id),
      .in_size   (req_if.entry_size),
      .in_hidden (req_if.is_hidden),
      .cmd       (cmd),
      .stat      (stat),
      .out_count (rsp_if.entry_count),
      .out_id    (rsp_if.chosen_id),
      .out_valid (rsp_if.has_choice),
      .out_taken (rsp_if.taken_now)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while a word is in work");

   a_taken_has_choice: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.taken_now) |-> rsp_if.has_choice)
      else $error("taken word without a held selection");

   a_no_choice_zero_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.has_choice) |-> (rsp_if.chosen_id == '0))
      else $error("nonzero id without a selection");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.exec, cmd.lcg_step, cmd.div_load, cmd.div_step,
                cmd.commit}))
      else $error("datapath commands overlap");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/rrp_ctrl.sv -----
// Controller state machine sequencing one word through the datapath.
`default_nettype none
module rrp_ctrl
   import rrp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire rrp_stat_type stat,
   output rrp_cmd_type       cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_MUL    = 6'b000100,
      S_DIVLD  = 6'b001000,
      S_DIV    = 6'b010000,
      S_COMMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_lcg ? S_MUL : S_COMMIT;
         end
         S_MUL: begin
            cmd.lcg_step = 1'b1;
            state_in     = stat.count_zero ? S_COMMIT : S_DIVLD;
         end
         S_DIVLD: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/rrp_dp.sv -----
// Datapath: item capture, seed/count/selection state, LCG step and serial modulo.
`default_nettype none
module rrp_dp
   import rrp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire logic [MAXSZ_W-1:0]  csr_wdata,
   input  wire logic [ACTION_W-1:0] in_action,
   input  wire logic [TIMER_W-1:0]  in_timer,
   input  wire logic [ID_W-1:0]     in_id,
   input  wire logic [SIZE_W-1:0]   in_size,
   input  wire logic                in_hidden,
   input  wire rrp_cmd_type         cmd,
   output rrp_stat_type             stat,
   output logic [COUNT_W-1:0]       out_count,
   output logic [ID_W-1:0]          out_id,
   output logic                     out_valid,
   output logic                     out_taken
);

   logic [MAXSZ_W-1:0]  max_size_ff, max_size_in;
   logic [ACTION_W-1:0] action_ff;
   logic [TIMER_W-1:0]  timer_ff;
   logic [ID_W-1:0]     id_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic                hidden_ff;
   logic [SEED_W-1:0]   seed_ff, seed_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ID_W-1:0]     pid_ff, pid_in;
   logic                pvalid_ff, pvalid_in;
   logic [COUNT_W-1:0]  dvd_ff, dvd_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  ocount_ff;
   logic [ID_W-1:0]     oid_ff;
   logic                ovalid_ff;
   logic                otaken_ff;

   logic                is_offer;
   logic                eligible;
   logic                taken;
   logic [SEED_W-1:0]   lcg_next;
   logic [COUNT_W:0]    trial;

   assign is_offer = (action_ff == ACT_OFFER);
   assign eligible = !hidden_ff && (size_ff != '0)
                     && (size_ff <= {{(SIZE_W-MAXSZ_W){1'b0}}, max_size_ff});
   assign lcg_next = seed_ff * LCG_MUL + LCG_ADD;
   assign trial    = {rem_ff, dvd_ff[COUNT_W-1]};
   assign taken    = is_offer && eligible
                     && ((count_ff == COUNT_W'(1)) || (count_ff == '0) || (rem_ff == '0));

   assign stat.need_lcg   = is_offer && eligible && (count_ff != '0);
   assign stat.count_zero = (count_ff == '0);
   assign stat.div_last   = (step_ff == '1);

   always_comb begin
      max_size_in = csr_write ? csr_wdata : max_size_ff;
      seed_in     = seed_ff;
      count_in    = count_ff;
      pid_in      = pid_ff;
      pvalid_in   = pvalid_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      if (cmd.exec) begin
         unique case (action_ff)
            ACT_SEED: begin
               seed_in   = timer_ff + SEED_OFFSET;
               pid_in    = '0;
               pvalid_in = 1'b0;
            end
            ACT_SCAN: begin
               seed_in   = seed_ff ^ timer_ff;
               count_in  = '0;
               pid_in    = '0;
               pvalid_in = 1'b0;
            end
            ACT_OFFER: begin
               if (eligible) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            default: ;
         endcase
      end
      if (cmd.lcg_step) begin
         seed_in = lcg_next;
      end
      if (cmd.div_load) begin
         dvd_in  = seed_ff[SEED_W-1 -: COUNT_W];
         rem_in  = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         dvd_in  = {dvd_ff[COUNT_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (trial >= {1'b0, count_ff}) begin
            rem_in = COUNT_W'(trial - {1'b0, count_ff});
         end else begin
            rem_in = trial[COUNT_W-1:0];
         end
      end
      if (cmd.commit && taken) begin
         pid_in    = id_ff;
         pvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
         seed_ff     <= SEED_RESET;
         count_ff    <= '0;
         pid_ff      <= '0;
         pvalid_ff   <= 1'b0;
      end else begin
         max_size_ff <= max_size_in;
         seed_ff     <= seed_in;
         count_ff    <= count_in;
         pid_ff      <= pid_in;
         pvalid_ff   <= pvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (cmd.capture) begin
         action_ff <= in_action;
         timer_ff  <= in_timer;
         id_ff     <= in_id;
         size_ff   <= in_size;
         hidden_ff <= in_hidden;
      end
      if (cmd.commit) begin
         ocount_ff <= count_ff;
         oid_ff    <= pid_in;
         ovalid_ff <= pvalid_in;
         otaken_ff <= taken;
      end
   end

   assign out_count = ocount_ff;
   assign out_id    = oid_ff;
   assign out_valid = ovalid_ff;
   assign out_taken = otaken_ff;

endmodule
`default_nettype wire

// ----- bench/tb_reservoir_random_pick_core.sv -----
// Self-checking testbench for reservoir_random_pick_core against a predictor.
`default_nettype none
module tb_reservoir_random_pick_core
   import rrp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
   localparam logic [MAXSZ_W-1:0]  SIZE_TOP = 21'd1048576;
   localparam int                  DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TIMER_W-1:0]  timer_value;
      logic [ID_W-1:0]     entry_id;
      logic [SIZE_W-1:0]   entry_size;
      logic                is_hidden;
   } pick_request_type;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic [ID_W-1:0]    chosen_id;
      logic               has_choice;
      logic               taken_now;
   } pick_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic [MAXSZ_W-1:0] csr_wdata = '0;

   rrp_req_if req_bus ();
   rrp_rsp_if rsp_bus ();

   reservoir_random_pick_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus)
   );

   // predictor state
   logic [SEED_W-1:0]  lcg_state      = SEED_RESET;
   logic [COUNT_W-1:0] seen_count     = '0;
   logic [ID_W-1:0]    held_id        = '0;
   logic               held_valid     = 1'b0;
   logic [MAXSZ_W-1:0] size_limit_now = MAX_SIZE_RESET;

   pick_request_type pending_words[$];
   pick_result_type  expected_picks[$];

   int fail_count    = 0;
   bit req_taken     = 1'b0;
   bit req_on_bus    = 1'b0;
   int send_idle_pct = 23;
   int recv_idle_pct = 71;

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      #60_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic pick_result_type predict_pick(pick_request_type w);
      pick_result_type r;
      logic            taken;
      taken = 1'b0;
      case (w.action)
         ACT_SEED: begin
            lcg_state  = w.timer_value + SEED_OFFSET;
            held_id    = '0;
            held_valid = 1'b0;
         end
         ACT_SCAN: begin
            lcg_state  = lcg_state ^ w.timer_value;
            seen_count = '0;
            held_id    = '0;
            held_valid = 1'b0;
         end
         ACT_OFFER: begin
            if (!w.is_hidden && w.entry_size != '0 && w.entry_size <= SIZE_W'(size_limit_now)) begin
               seen_count = seen_count + 1'b1;
               if (seen_count == COUNT_W'(1)) begin
                  taken = 1'b1;
               end else begin
                  lcg_state = lcg_state * LCG_MUL + LCG_ADD;
                  if (seen_count == '0) begin
                     taken = 1'b1;
                  end else if (lcg_state[SEED_W-1:16] % seen_count == '0) begin
                     taken = 1'b1;
                  end
               end
               if (taken) begin
                  held_id    = w.entry_id;
                  held_valid = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.entry_count = seen_count;
      r.chosen_id   = held_id;
      r.has_choice  = held_valid;
      r.taken_now   = taken;
      return r;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   function automatic pick_request_type random_word(logic [MAXSZ_W-1:0] limit);
      pick_request_type w;
      int unsigned      roll;
      w.action      = ACT_OFFER;
      w.timer_value = $urandom();
      w.entry_id    = ID_W'($urandom());
      w.entry_size  = $urandom();
      w.is_hidden   = ($urandom_range(9, 0) == 0);
      roll = $urandom_range(99, 0);
      if (roll < 6) begin
         w.action = ACT_SEED;
      end else if (roll < 14) begin
         w.action = ACT_SCAN;
      end else if (roll < 18) begin
         w.action    = ACT_NONE;
         w.is_hidden = 1'($urandom_range(1, 0));
      end else begin
         roll = $urandom_range(9, 0);
         if (roll < 6 && limit != '0) begin
            w.entry_size = $urandom_range(limit, 1);
         end else if (roll == 6) begin
            w.entry_size = SIZE_W'(limit);
         end else if (roll == 7) begin
            w.entry_size = limit + 1;
         end else if (roll == 8) begin
            w.entry_size = '0;
         end
      end
      return w;
   endfunction

   task automatic queue_word(logic [ACTION_W-1:0] act, logic [TIMER_W-1:0] tmr,
                             logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz, logic hid);
      pending_words.push_back('{act, tmr, id, sz, hid});
   endtask

   // returns once no word is queued, on the bus or awaiting its response
   task automatic wait_drained();
      @(posedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_picks.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_max_size(logic [MAXSZ_W-1:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic run_random(logic [MAXSZ_W-1:0] limit, int count);
      for (int i = 0; i < count / 2; i++) pending_words.push_back(random_word(limit));
      wait_drained();
      for (int i = count / 2; i < count; i++) pending_words.push_back(random_word(limit));
   endtask

   // request driver
   always @(negedge clock) begin : drive_requests
      pick_request_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
         req_on_bus = 1'b0;
      end else begin
         if (req_taken) begin
            req_on_bus = 1'b0;
            req_taken  = 1'b0;
         end
         if (!req_on_bus) begin
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               w = pending_words.pop_front();
               req_bus.action      <= w.action;
               req_bus.timer_value <= w.timer_value;
               req_bus.entry_id    <= w.entry_id;
               req_bus.entry_size  <= w.entry_size;
               req_bus.is_hidden   <= w.is_hidden;
               req_bus.valid       <= 1'b1;
               req_on_bus = 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin : watch_ports
      pick_request_type w;
      pick_result_type  want;
      if (!reset) begin
         if (csr_write) size_limit_now = csr_wdata;
         if (req_bus.valid && req_bus.ready) begin
            w = '{req_bus.action, req_bus.timer_value, req_bus.entry_id,
                  req_bus.entry_size, req_bus.is_hidden};
            expected_picks.push_back(predict_pick(w));
            req_taken = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_picks.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, actual count %0h id %0h",
                        $time, rsp_bus.entry_count, rsp_bus.chosen_id,
                        " choice %0b taken %0b", rsp_bus.has_choice, rsp_bus.taken_now);
            end else begin
               want = expected_picks.pop_front();
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_bus.entry_count));
               check_field("chosen_id", 32'(want.chosen_id), 32'(rsp_bus.chosen_id));
               check_field("has_choice", 32'(want.has_choice), 32'(rsp_bus.has_choice));
               check_field("taken_now", 32'(want.taken_now), 32'(rsp_bus.taken_now));
            end
         end
      end
   end

   initial begin : run_sequence
      logic [MAXSZ_W-1:0] limits [7];
      req_bus.valid       = 1'b0;
      req_bus.action      = '0;
      req_bus.timer_value = '0;
      req_bus.entry_id    = '0;
      req_bus.entry_size  = '0;
      req_bus.is_hidden   = 1'b0;
      rsp_bus.ready       = 1'b0;

      limits[0] = 21'd1;
      limits[1] = 21'd0;
      limits[2] = SIZE_TOP;
      limits[3] = 21'h1FFFFF;
      limits[4] = MAXSZ_W'($urandom_range(21'h1FFFFF, 1));
      limits[5] = MAX_SIZE_RESET;
      limits[6] = MAXSZ_W'($urandom_range(65535, 1));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed words at the reset value of max_size
      queue_word(ACT_OFFER, '0, 16'hFFFF, 32'd1, 1'b0);
      queue_word(ACT_OFFER, 32'hFFFF_FFFF, '0, 32'd32768, 1'b0);
      queue_word(ACT_OFFER, '0, 16'h1234, 32'd32769, 1'b0);
      queue_word(ACT_OFFER, '0, 16'h1235, '0, 1'b0);
      queue_word(ACT_OFFER, '0, 16'h1236, 32'd100, 1'b1);
      queue_word(ACT_OFFER, '0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_word(ACT_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      queue_word(ACT_SEED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      queue_word(ACT_OFFER, '0, 16'h0001, 32'd1, 1'b0);
      queue_word(ACT_SCAN, 32'hFFFF_FFFF, '0, '0, 1'b0);
      for (int i = 0; i < 6; i++) begin
         queue_word(ACT_OFFER, '0, ID_W'($urandom()), $urandom_range(32768, 1), 1'b0);
      end
      queue_word(ACT_SEED, '0, '0, '0, 1'b0);
      queue_word(ACT_OFFER, '0, 16'h00A5, 32'd512, 1'b0);
      queue_word(ACT_NONE, '0, '0, '0, 1'b0);
      queue_word(ACT_SCAN, 32'hA5A5_5A5A, '0, '0, 1'b0);
      for (int i = 0; i < 3; i++) begin
         queue_word(ACT_OFFER, '0, ID_W'($urandom()), $urandom_range(32768, 1), 1'b0);
      end

      for (int p = 0; p < 7; p++) begin
         if (p == 2) begin
            send_idle_pct = 71;
            recv_idle_pct = 23;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_max_size(limits[p]);
         run_random(limits[p], 103);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/rrp_pkg.sv
rtl/core/rrp_intf.sv
rtl/core/rrp_ctrl.sv
rtl/core/rrp_dp.sv
rtl/core/reservoir_random_pick_core.sv
bench/tb_reservoir_random_pick_core.sv
